/* rtl/dtq_pkg.sv */
// types, codes and helpers shared by the deadline timer queue
`default_nettype none
package dtq_pkg;

  // largest 48-bit millisecond time
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_ADD     = 3'd0,
    KIND_CANCEL  = 3'd1,
    KIND_RESCHED = 3'd2,
    KIND_TICK    = 3'd3,
    KIND_REPLY   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  // per-slot sweep operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FREE,
    OP_COUNT,
    OP_UP,
    OP_DOWN,
    OP_HEAD
  } sweep_e;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ADD,
    ACT_CANCEL,
    ACT_RESCH_PER,
    ACT_RESCH_DL,
    ACT_RANK_WR,
    ACT_GRAB,
    ACT_TAKE,
    ACT_STOP,
    ACT_ARM
  } act_e;

  // result beat kinds
  typedef enum logic [2:0] {
    EM_NONE,
    EM_OK,
    EM_FULL,
    EM_BAD,
    EM_ADD,
    EM_EXP,
    EM_WAIT
  } emit_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FREE,
    ST_ADD,
    ST_COUNT,
    ST_UP,
    ST_RANK,
    ST_GRAB,
    ST_RS_CMP,
    ST_DOWN,
    ST_HEAD,
    ST_HEAD_CHK,
    ST_ARM
  } state_e;

  typedef struct packed {
    logic   load;
    sweep_e op;
    logic   issue;
    act_e   act;
    emit_e  emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       chk_ok;
    logic       inq_sel;
    logic       found;
    logic       due_le;
    logic       dl_diff;
    logic       rv_neg;
  } stat_t;

  // deadline = now + delay, saturated at the 48-bit limit
  function automatic logic [47:0] due_at(input logic [47:0] now, input logic [31:0] dly);
    logic [48:0] s;
    s = {1'b0, now} + {17'b0, dly};
    return s[48] ? MAX48 : s[47:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/dtq_datapath.sv */
// slot store, rank memory, sweep processing and result registers
`default_nettype none
module dtq_datapath #(
  parameter int SLOTS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  dtq_pkg::cmd_t                cmd_i,
  input  wire [$clog2(SLOTS+1)-1:0]    cnt_i,
  output dtq_pkg::stat_t               stat_o,
  input  wire [2:0]                    kind_i,
  input  wire [47:0]                   now_ms_i,
  input  wire [3:0]                    timer_id_i,
  input  wire [31:0]                   delay_ms_i,
  input  wire signed [31:0]            reply_value_i,
  output logic                         valid_o,
  output logic [1:0]                   status_o,
  output logic [3:0]                   timer_id_res_o,
  output logic                         expired_o,
  output logic [31:0]                  wait_ms_o,
  output logic                         last_o
);
  localparam int SW = $clog2(SLOTS);

  // slot flags
  logic [SLOTS-1:0] used_q, await_q;
  // memories
  logic [47:0]   dl_mem [SLOTS];
  logic [31:0]   pr_mem [SLOTS];
  logic [SW-1:0] rk_mem [SLOTS];
  logic [47:0]   dl_rd_q;
  logic [31:0]   pr_rd_q;
  logic [SW-1:0] rk_rd_q;
  // item registers
  logic [2:0]    kind_q;
  logic [47:0]   now_q, dl_new_q, dl_head_q;
  logic [31:0]   delay_q, rv_q;
  logic          id_ok_q;
  logic [SW-1:0] sel_q, head_q, tgt_q, r_q, p_idx_q;
  logic          p_vld_q, found_q;
  // result registers
  logic          o_valid_q, o_exp_q, o_last_q;
  logic [1:0]    o_status_q;
  logic [3:0]    o_id_q;
  logic [31:0]   o_wait_q;
  logic          o_exp_d, o_last_d;
  logic [1:0]    o_status_d;
  logic [3:0]    o_id_d;
  logic [31:0]   o_wait_d;

  logic [SW-1:0] raddr;
  logic          p_inq, p_other, sweep_clr;
  logic [31:0]   arm_per;
  logic [47:0]   arm_dl, w48;
  logic          dl_we, pr_we, rk_we;
  logic [47:0]   dl_wd;
  logic [31:0]   pr_wd;
  logic [SW-1:0] rk_wa, rk_wd;

  assign raddr     = cmd_i.issue ? cnt_i[SW-1:0] : sel_q;
  assign p_inq     = used_q[p_idx_q] & ~await_q[p_idx_q];
  assign p_other   = (p_idx_q != sel_q);
  assign sweep_clr = cmd_i.issue && (cnt_i == '0) &&
                     (cmd_i.op == dtq_pkg::OP_FREE || cmd_i.op == dtq_pkg::OP_COUNT ||
                      cmd_i.op == dtq_pkg::OP_HEAD);
  assign arm_per   = (rv_q != '0) ? rv_q : pr_rd_q;
  assign arm_dl    = dtq_pkg::due_at(now_q, arm_per);
  assign w48       = dl_head_q - now_q;

  // memory write selection
  always_comb begin
    dl_we = 1'b0;
    dl_wd = dl_new_q;
    pr_we = 1'b0;
    pr_wd = delay_q;
    rk_we = 1'b0;
    rk_wa = sel_q;
    rk_wd = r_q;
    case (cmd_i.act)
      dtq_pkg::ACT_ADD: begin
        dl_we = 1'b1;
        pr_we = 1'b1;
      end
      dtq_pkg::ACT_RESCH_PER: pr_we = 1'b1;
      dtq_pkg::ACT_RESCH_DL:  dl_we = 1'b1;
      dtq_pkg::ACT_RANK_WR:   rk_we = 1'b1;
      dtq_pkg::ACT_ARM: begin
        dl_we = 1'b1;
        dl_wd = arm_dl;
        pr_we = (rv_q != '0);
        pr_wd = rv_q;
      end
      default: ;
    endcase
    if (p_vld_q && p_inq && p_other) begin
      if (cmd_i.op == dtq_pkg::OP_UP && rk_rd_q >= r_q) begin
        rk_we = 1'b1;
        rk_wa = p_idx_q;
        rk_wd = rk_rd_q + SW'(1);
      end else if (cmd_i.op == dtq_pkg::OP_DOWN && rk_rd_q > tgt_q) begin
        rk_we = 1'b1;
        rk_wa = p_idx_q;
        rk_wd = rk_rd_q - SW'(1);
      end
    end
  end

  // memories with registered read
  always_ff @(posedge clk_i) begin
    dl_rd_q <= dl_mem[raddr];
    pr_rd_q <= pr_mem[raddr];
    rk_rd_q <= rk_mem[raddr];
    if (dl_we) dl_mem[sel_q] <= dl_wd;
    if (pr_we) pr_mem[sel_q] <= pr_wd;
    if (rk_we) rk_mem[rk_wa] <= rk_wd;
  end

  // slot flags and sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      await_q <= '0;
      found_q <= 1'b0;
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.issue;
      if (sweep_clr) found_q <= 1'b0;
      if (p_vld_q) begin
        if (cmd_i.op == dtq_pkg::OP_FREE && !used_q[p_idx_q] && !found_q) found_q <= 1'b1;
        if (cmd_i.op == dtq_pkg::OP_HEAD && p_inq && rk_rd_q == '0) found_q <= 1'b1;
      end
      case (cmd_i.act)
        dtq_pkg::ACT_ADD: begin
          used_q[sel_q]  <= 1'b1;
          await_q[sel_q] <= 1'b0;
        end
        dtq_pkg::ACT_CANCEL, dtq_pkg::ACT_STOP: begin
          used_q[sel_q]  <= 1'b0;
          await_q[sel_q] <= 1'b0;
        end
        dtq_pkg::ACT_TAKE: await_q[head_q] <= 1'b1;
        dtq_pkg::ACT_ARM:  await_q[sel_q]  <= 1'b0;
        default: ;
      endcase
    end
  end

  // item and sweep payload registers
  always_ff @(posedge clk_i) begin
    p_idx_q <= cnt_i[SW-1:0];
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      now_q    <= now_ms_i;
      delay_q  <= delay_ms_i;
      rv_q     <= reply_value_i;
      id_ok_q  <= (32'(timer_id_i) < SLOTS);
      sel_q    <= SW'(timer_id_i);
      dl_new_q <= dtq_pkg::due_at(now_ms_i, delay_ms_i);
    end
    if (sweep_clr) r_q <= '0;
    if (p_vld_q) begin
      if (cmd_i.op == dtq_pkg::OP_FREE && !used_q[p_idx_q] && !found_q) sel_q <= p_idx_q;
      if (cmd_i.op == dtq_pkg::OP_COUNT && p_inq && p_other && dl_rd_q < dl_new_q)
        r_q <= r_q + SW'(1);
      if (cmd_i.op == dtq_pkg::OP_HEAD && p_inq && rk_rd_q == '0) begin
        head_q    <= p_idx_q;
        dl_head_q <= dl_rd_q;
      end
    end
    case (cmd_i.act)
      dtq_pkg::ACT_GRAB: tgt_q <= rk_rd_q;
      dtq_pkg::ACT_TAKE: begin
        sel_q <= head_q;
        tgt_q <= '0;
      end
      dtq_pkg::ACT_ARM: dl_new_q <= arm_dl;
      default: ;
    endcase
  end

  // result beat registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= (cmd_i.emit != dtq_pkg::EM_NONE);
    end
  end

  // next result beat fields
  always_comb begin
    o_status_d = dtq_pkg::STAT_OK;
    o_id_d     = '0;
    o_exp_d    = 1'b0;
    o_wait_d   = '0;
    o_last_d   = 1'b1;
    case (cmd_i.emit)
      dtq_pkg::EM_FULL: o_status_d = dtq_pkg::STAT_FULL;
      dtq_pkg::EM_BAD:  o_status_d = dtq_pkg::STAT_BAD;
      dtq_pkg::EM_ADD:  o_id_d     = 4'(sel_q);
      dtq_pkg::EM_EXP: begin
        o_id_d   = 4'(head_q);
        o_exp_d  = 1'b1;
        o_last_d = 1'b0;
      end
      dtq_pkg::EM_WAIT: o_wait_d = (w48[47:32] != '0) ? 32'hFFFF_FFFF : w48[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    o_status_q <= o_status_d;
    o_id_q     <= o_id_d;
    o_exp_q    <= o_exp_d;
    o_wait_q   <= o_wait_d;
    o_last_q   <= o_last_d;
  end

  // status towards the controller
  always_comb begin
    stat_o.kind    = kind_q;
    stat_o.inq_sel = used_q[sel_q] & ~await_q[sel_q];
    stat_o.found   = found_q;
    stat_o.due_le  = (dl_head_q <= now_q);
    stat_o.dl_diff = (dl_new_q != dl_rd_q);
    stat_o.rv_neg  = rv_q[31];
    case (kind_q)
      dtq_pkg::KIND_CANCEL:  stat_o.chk_ok = id_ok_q && used_q[sel_q];
      dtq_pkg::KIND_RESCHED: stat_o.chk_ok = id_ok_q && used_q[sel_q] && !await_q[sel_q];
      dtq_pkg::KIND_REPLY:   stat_o.chk_ok = id_ok_q && used_q[sel_q] && await_q[sel_q];
      default:               stat_o.chk_ok = 1'b1;
    endcase
  end

  assign valid_o        = o_valid_q;
  assign status_o       = o_status_q;
  assign timer_id_res_o = o_id_q;
  assign expired_o      = o_exp_q;
  assign wait_ms_o      = o_wait_q;
  assign last_o         = o_last_q;

endmodule
`default_nettype wire

/* rtl/dtq_ctrl.sv */
// controller state machine sequencing slot sweeps and actions
`default_nettype none
module dtq_ctrl #(
  parameter int SLOTS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  dtq_pkg::stat_t               stat_i,
  output dtq_pkg::cmd_t                cmd_o,
  output logic [$clog2(SLOTS+1)-1:0]   cnt_o
);
  localparam int CW = $clog2(SLOTS+1);

  dtq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            sweep, last;

  // state and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtq_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign sweep = (state_q == dtq_pkg::ST_FREE) || (state_q == dtq_pkg::ST_COUNT) ||
                 (state_q == dtq_pkg::ST_UP) || (state_q == dtq_pkg::ST_DOWN) ||
                 (state_q == dtq_pkg::ST_HEAD);
  assign last  = (cnt_q == CW'(SLOTS));

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.issue = sweep && !last;
    cnt_d     = (sweep && !last) ? cnt_q + CW'(1) : '0;
    case (state_q)
      dtq_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = dtq_pkg::ST_DECODE;
        end
      end
      dtq_pkg::ST_DECODE: begin
        case (stat_i.kind)
          dtq_pkg::KIND_ADD:  state_d = dtq_pkg::ST_FREE;
          dtq_pkg::KIND_TICK: state_d = dtq_pkg::ST_HEAD;
          dtq_pkg::KIND_CANCEL: begin
            if (!stat_i.chk_ok) begin
              cmd_o.emit = dtq_pkg::EM_BAD;
              state_d    = dtq_pkg::ST_IDLE;
            end else if (stat_i.inq_sel) begin
              state_d = dtq_pkg::ST_GRAB;
            end else begin
              cmd_o.act  = dtq_pkg::ACT_CANCEL;
              cmd_o.emit = dtq_pkg::EM_OK;
              state_d    = dtq_pkg::ST_IDLE;
            end
          end
          dtq_pkg::KIND_RESCHED: begin
            if (!stat_i.chk_ok) begin
              cmd_o.emit = dtq_pkg::EM_BAD;
              state_d    = dtq_pkg::ST_IDLE;
            end else begin
              cmd_o.act = dtq_pkg::ACT_RESCH_PER;
              state_d   = dtq_pkg::ST_RS_CMP;
            end
          end
          dtq_pkg::KIND_REPLY: begin
            if (!stat_i.chk_ok) begin
              cmd_o.emit = dtq_pkg::EM_BAD;
              state_d    = dtq_pkg::ST_IDLE;
            end else if (stat_i.rv_neg) begin
              cmd_o.act  = dtq_pkg::ACT_STOP;
              cmd_o.emit = dtq_pkg::EM_OK;
              state_d    = dtq_pkg::ST_IDLE;
            end else begin
              state_d = dtq_pkg::ST_ARM;
            end
          end
          default: begin
            cmd_o.emit = dtq_pkg::EM_OK;
            state_d    = dtq_pkg::ST_IDLE;
          end
        endcase
      end
      // lowest free slot
      dtq_pkg::ST_FREE: begin
        cmd_o.op = dtq_pkg::OP_FREE;
        if (last) state_d = dtq_pkg::ST_ADD;
      end
      dtq_pkg::ST_ADD: begin
        if (!stat_i.found) begin
          cmd_o.emit = dtq_pkg::EM_FULL;
          state_d    = dtq_pkg::ST_IDLE;
        end else begin
          cmd_o.act = dtq_pkg::ACT_ADD;
          state_d   = dtq_pkg::ST_COUNT;
        end
      end
      // insert: count earlier deadlines, then open a gap
      dtq_pkg::ST_COUNT: begin
        cmd_o.op = dtq_pkg::OP_COUNT;
        if (last) state_d = dtq_pkg::ST_UP;
      end
      dtq_pkg::ST_UP: begin
        cmd_o.op = dtq_pkg::OP_UP;
        if (last) state_d = dtq_pkg::ST_RANK;
      end
      dtq_pkg::ST_RANK: begin
        cmd_o.act  = dtq_pkg::ACT_RANK_WR;
        cmd_o.emit = (stat_i.kind == dtq_pkg::KIND_ADD) ? dtq_pkg::EM_ADD : dtq_pkg::EM_OK;
        state_d    = dtq_pkg::ST_IDLE;
      end
      dtq_pkg::ST_GRAB: begin
        cmd_o.act = dtq_pkg::ACT_GRAB;
        state_d   = dtq_pkg::ST_DOWN;
      end
      dtq_pkg::ST_RS_CMP: begin
        if (stat_i.dl_diff) begin
          cmd_o.act = dtq_pkg::ACT_GRAB;
          state_d   = dtq_pkg::ST_DOWN;
        end else begin
          cmd_o.emit = dtq_pkg::EM_OK;
          state_d    = dtq_pkg::ST_IDLE;
        end
      end
      // removal: close the gap behind the slot
      dtq_pkg::ST_DOWN: begin
        cmd_o.op = dtq_pkg::OP_DOWN;
        if (last) begin
          case (stat_i.kind)
            dtq_pkg::KIND_CANCEL: begin
              cmd_o.act  = dtq_pkg::ACT_CANCEL;
              cmd_o.emit = dtq_pkg::EM_OK;
              state_d    = dtq_pkg::ST_IDLE;
            end
            dtq_pkg::KIND_RESCHED: begin
              cmd_o.act = dtq_pkg::ACT_RESCH_DL;
              state_d   = dtq_pkg::ST_COUNT;
            end
            dtq_pkg::KIND_TICK: begin
              cmd_o.emit = dtq_pkg::EM_EXP;
              state_d    = dtq_pkg::ST_HEAD;
            end
            default: state_d = dtq_pkg::ST_IDLE;
          endcase
        end
      end
      // tick: find the head of the queue
      dtq_pkg::ST_HEAD: begin
        cmd_o.op = dtq_pkg::OP_HEAD;
        if (last) state_d = dtq_pkg::ST_HEAD_CHK;
      end
      dtq_pkg::ST_HEAD_CHK: begin
        if (!stat_i.found) begin
          cmd_o.emit = dtq_pkg::EM_OK;
          state_d    = dtq_pkg::ST_IDLE;
        end else if (stat_i.due_le) begin
          cmd_o.act = dtq_pkg::ACT_TAKE;
          state_d   = dtq_pkg::ST_DOWN;
        end else begin
          cmd_o.emit = dtq_pkg::EM_WAIT;
          state_d    = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_ARM: begin
        cmd_o.act = dtq_pkg::ACT_ARM;
        state_d   = dtq_pkg::ST_COUNT;
      end
      default: state_d = dtq_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != dtq_pkg::ST_IDLE);
  assign cnt_o  = cnt_q;

endmodule
`default_nettype wire

/* rtl/deadline_timer_queue.sv */
// sorted one-shot and repeating millisecond timer queue, top level
// adds, ticks, re-arms and queue removals sweep the slot memories one slot per cycle
// tick: each expired timer is reported in its own beat ahead of the final beat
// one item at a time; the receiver cannot stall, each beat shows for one cycle
// reset clears all slots to free; slot memories need no clearing pass
`default_nettype none
module deadline_timer_queue #(
  parameter int SLOTS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  output logic              busy_o,
  input  wire [2:0]         kind_i,
  input  wire [47:0]        now_ms_i,
  input  wire [3:0]         timer_id_i,
  input  wire [31:0]        delay_ms_i,
  input  wire signed [31:0] reply_value_i,
  output logic              valid_o,
  output logic [1:0]        status_o,
  output logic [3:0]        timer_id_res_o,
  output logic              expired_o,
  output logic [31:0]       wait_ms_o,
  output logic              last_o
);
  dtq_pkg::cmd_t              cmd;
  dtq_pkg::stat_t             stat;
  logic [$clog2(SLOTS+1)-1:0] cnt;

  // sequencer
  dtq_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd),
    .cnt_o  (cnt)
  );

  // slot store and result path
  dtq_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cnt_i         (cnt),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .now_ms_i      (now_ms_i),
    .timer_id_i    (timer_id_i),
    .delay_ms_i    (delay_ms_i),
    .reply_value_i (reply_value_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .timer_id_res_o(timer_id_res_o),
    .expired_o     (expired_o),
    .wait_ms_o     (wait_ms_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

/* rtl/dtq_checker.sv */
// port-level checks for the deadline timer queue and their binding
`default_nettype none
module dtq_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               start_i,
  input wire               busy_o,
  input wire               valid_o,
  input wire [1:0]         status_o,
  input wire               expired_o,
  input wire [31:0]        wait_ms_o,
  input wire               last_o
);

  // an accepted beat makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted beat did not raise busy");

  // no result appears from an idle block
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !start_i |=> !valid_o) else $error("result from idle block");

  // an expiry report is never the final beat and carries no wait
  a_exp_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && expired_o |-> !last_o && status_o == dtq_pkg::STAT_OK && wait_ms_o == '0)
    else $error("malformed expiry beat");

  // an error result is a single final beat
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != dtq_pkg::STAT_OK |-> last_o && !expired_o)
    else $error("error beat not final");

  // more beats follow a non-final one
  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> busy_o) else $error("block idle after non-final beat");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
`default_nettype wire

/* dv/tb_deadline_timer_queue.sv */
// testbench for the deadline timer queue: directed table, a fill-up run, then random command traffic
`default_nettype none
module tb_deadline_timer_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [31:0] RV_STOP = 32'hFFFF_FFFF;
  localparam logic [31:0] RV_KEEP = 32'd0;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [2:0]        kind_i = '0;
  logic [47:0]       now_ms_i = '0;
  logic [3:0]        timer_id_i = '0;
  logic [31:0]       delay_ms_i = '0;
  logic signed [31:0] reply_value_i = '0;
  logic              valid_o;
  logic [1:0]        status_o;
  logic [3:0]        timer_id_res_o;
  logic              expired_o;
  logic [31:0]       wait_ms_o;
  logic              last_o;

  deadline_timer_queue #(.SLOTS(NSLOT)) DUT (.*);

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  id;
    logic        expired;
    logic [31:0] wait_ms;
    logic        last;
  } beat_t;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] now;
    logic [3:0]  id;
    logic [31:0] dly;
    logic [31:0] rv;
    bit          typed;
    dtq_pkg::status_e st;
    logic [3:0]  rid;
  } row_t;

  // expected beats, oldest first
  beat_t pending_beats[$];
  int    errors = 0;
  int    items_sent = 0;
  int    expiries_seen = 0;
  int    beats_seen = 0;
  bit    allow_idle = 1'b1;

  // timer table mirror
  bit          used_m[NSLOT];
  bit          await_m[NSLOT];
  logic [47:0] dl_m[NSLOT];
  logic [31:0] per_m[NSLOT];
  int          rank_m[NSLOT];

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_deadline_timer_queue: errors");
    $finish;
  end

  function automatic bit queued(int j);
    return used_m[j] && !await_m[j];
  endfunction

  function automatic logic [47:0] deadline_of(logic [47:0] now, logic [31:0] dly);
    logic [48:0] s;
    s = {1'b0, now} + {17'd0, dly};
    return s[48] ? dtq_pkg::MAX48 : s[47:0];
  endfunction

  function automatic void rank_insert(int i);
    int r;
    r = 0;
    for (int j = 0; j < NSLOT; j++)
      if (j != i && queued(j) && dl_m[j] < dl_m[i]) r++;
    for (int j = 0; j < NSLOT; j++)
      if (j != i && queued(j) && rank_m[j] >= r) rank_m[j]++;
    rank_m[i] = r;
  endfunction

  function automatic void rank_remove(int i);
    for (int j = 0; j < NSLOT; j++)
      if (j != i && queued(j) && rank_m[j] > rank_m[i]) rank_m[j]--;
  endfunction

  function automatic void push_beat(logic [1:0] st, logic [3:0] id, logic ex,
                                    logic [31:0] w, logic lst);
    beat_t b;
    b.status = st; b.id = id; b.expired = ex; b.wait_ms = w; b.last = lst;
    pending_beats.push_back(b);
  endfunction

  // work out the beats one command produces and update the mirror
  function automatic void timer_queue_predict(logic [2:0] kind, logic [47:0] now,
                                              logic [3:0] id, logic [31:0] dly,
                                              logic [31:0] rv);
    int h;
    int f;
    logic [47:0] d;
    logic [47:0] w;
    case (kind)
      dtq_pkg::KIND_ADD: begin
        f = -1;
        for (int j = NSLOT - 1; j >= 0; j--) if (!used_m[j]) f = j;
        if (f < 0) begin
          push_beat(dtq_pkg::STAT_FULL, 0, 0, 0, 1);
        end else begin
          used_m[f] = 1; await_m[f] = 0; per_m[f] = dly;
          dl_m[f] = deadline_of(now, dly);
          rank_insert(f);
          push_beat(dtq_pkg::STAT_OK, 4'(f), 0, 0, 1);
        end
      end
      dtq_pkg::KIND_CANCEL: begin
        if (!used_m[id]) begin
          push_beat(dtq_pkg::STAT_BAD, 0, 0, 0, 1);
        end else begin
          if (queued(id)) rank_remove(id);
          used_m[id] = 0; await_m[id] = 0;
          push_beat(dtq_pkg::STAT_OK, 0, 0, 0, 1);
        end
      end
      dtq_pkg::KIND_RESCHED: begin
        if (!queued(id)) begin
          push_beat(dtq_pkg::STAT_BAD, 0, 0, 0, 1);
        end else begin
          per_m[id] = dly;
          d = deadline_of(now, dly);
          if (d != dl_m[id]) begin
            rank_remove(id);
            dl_m[id] = d;
            rank_insert(id);
          end
          push_beat(dtq_pkg::STAT_OK, 0, 0, 0, 1);
        end
      end
      dtq_pkg::KIND_TICK: begin
        forever begin
          h = -1;
          for (int j = 0; j < NSLOT; j++) if (queued(j) && rank_m[j] == 0 && h < 0) h = j;
          if (h < 0) begin
            push_beat(dtq_pkg::STAT_OK, 0, 0, 0, 1);
            break;
          end
          if (dl_m[h] <= now) begin
            rank_remove(h);
            await_m[h] = 1;
            push_beat(dtq_pkg::STAT_OK, 4'(h), 1, 0, 0);
          end else begin
            w = dl_m[h] - now;
            push_beat(dtq_pkg::STAT_OK, 0, 0, (w > {16'd0, MAX32}) ? MAX32 : w[31:0], 1);
            break;
          end
        end
      end
      dtq_pkg::KIND_REPLY: begin
        if (!used_m[id] || !await_m[id]) begin
          push_beat(dtq_pkg::STAT_BAD, 0, 0, 0, 1);
        end else if (rv[31]) begin
          used_m[id] = 0; await_m[id] = 0;
          push_beat(dtq_pkg::STAT_OK, 0, 0, 0, 1);
        end else begin
          if (rv != 0) per_m[id] = rv;
          dl_m[id] = deadline_of(now, per_m[id]);
          await_m[id] = 0;
          rank_insert(id);
          push_beat(dtq_pkg::STAT_OK, 0, 0, 0, 1);
        end
      end
      default: push_beat(dtq_pkg::STAT_OK, 0, 0, 0, 1);
    endcase
  endfunction

  // present one command, wait for acceptance, then maybe idle
  task automatic send_command(logic [2:0] kind, logic [47:0] now, logic [3:0] id,
                              logic [31:0] dly, logic [31:0] rv, bit typed,
                              dtq_pkg::status_e st, logic [3:0] rid);
    int n;
    start_i <= 1'b1;
    kind_i <= kind;
    now_ms_i <= now;
    timer_id_i <= id;
    delay_ms_i <= dly;
    reply_value_i <= rv;
    do @(posedge clk_i); while (busy_o);
    n = pending_beats.size();
    timer_queue_predict(kind, now, id, dly, rv);
    // typed-in expectation for single-beat rows
    if (typed) begin
      pending_beats[n].status = st;
      pending_beats[n].id = rid;
      pending_beats[n].expired = 1'b0;
      pending_beats[n].wait_ms = '0;
      pending_beats[n].last = 1'b1;
    end
    items_sent++;
    if (allow_idle && $urandom_range(99) < 22) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // result checking
  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni && valid_o) begin
      beats_seen++;
      if (expired_o) expiries_seen++;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: status %0d id %0d", status_o, timer_id_res_o);
        errors++;
      end else begin
        b = pending_beats.pop_front();
        if (status_o !== b.status) begin
          $error("status: expected %0d, got %0d", b.status, status_o); errors++;
        end
        if (timer_id_res_o !== b.id) begin
          $error("timer_id_res: expected %0d, got %0d", b.id, timer_id_res_o); errors++;
        end
        if (expired_o !== b.expired) begin
          $error("expired: expected %0d, got %0d", b.expired, expired_o); errors++;
        end
        if (wait_ms_o !== b.wait_ms) begin
          $error("wait_ms: expected %0d, got %0d", b.wait_ms, wait_ms_o); errors++;
        end
        if (last_o !== b.last) begin
          $error("last: expected %0d, got %0d", b.last, last_o); errors++;
        end
      end
    end
  end

  function automatic int pick_slot(bit want_await);
    int c;
    c = $urandom_range(NSLOT - 1);
    for (int k = 0; k < NSLOT; k++) begin
      if (used_m[(c + k) % NSLOT] && (await_m[(c + k) % NSLOT] == want_await))
        return (c + k) % NSLOT;
    end
    return c;
  endfunction

  row_t directed[20];

  initial begin
    logic [47:0] clock_ms;
    logic [2:0]  kind;
    logic [47:0] now;
    logic [31:0] dly;
    logic [31:0] rv;
    int          pick;
    int          slot;

    directed = '{
      '{dtq_pkg::KIND_TICK,    48'd0,   4'd0,  32'd0, 32'd0, 1, dtq_pkg::STAT_OK,  4'd0},
      '{dtq_pkg::KIND_CANCEL,  48'd0,   4'd0,  32'd0, 32'd0, 1, dtq_pkg::STAT_BAD, 4'd0},
      '{dtq_pkg::KIND_RESCHED, 48'd0,   4'd15, 32'd0, 32'd0, 1, dtq_pkg::STAT_BAD, 4'd0},
      '{dtq_pkg::KIND_REPLY,   48'd0,   4'd7,  32'd0, 32'd0, 1, dtq_pkg::STAT_BAD, 4'd0},
      '{KIND_SPARE_LO,  48'd9,   4'd3,  32'd9,  32'd9,  1, dtq_pkg::STAT_OK,  4'd0},
      '{KIND_SPARE_MID, 48'd9,   4'd3,  32'd9,  32'd9,  1, dtq_pkg::STAT_OK,  4'd0},
      '{KIND_SPARE_HI, dtq_pkg::MAX48, 4'd15, MAX32, MAX32, 1, dtq_pkg::STAT_OK, 4'd0},
      '{dtq_pkg::KIND_ADD, 48'd0,          4'd0, 32'd0, 32'd0, 1, dtq_pkg::STAT_OK, 4'd0},
      '{dtq_pkg::KIND_ADD, dtq_pkg::MAX48, 4'd0, MAX32, 32'd0, 1, dtq_pkg::STAT_OK, 4'd1},
      '{dtq_pkg::KIND_ADD, 48'd100,        4'd0, 32'd5, 32'd0, 1, dtq_pkg::STAT_OK, 4'd2},
      // equal deadline goes ahead of slot 2
      '{dtq_pkg::KIND_ADD, 48'd101,        4'd0, 32'd4, 32'd0, 1, dtq_pkg::STAT_OK, 4'd3},
      // same deadline again: no move
      '{dtq_pkg::KIND_RESCHED, dtq_pkg::MAX48, 4'd1, 32'd0, 32'd0, 0, dtq_pkg::STAT_OK, 4'd0},
      '{dtq_pkg::KIND_TICK,  48'd105, 4'd0, 32'd0, 32'd0,   0, dtq_pkg::STAT_OK,  4'd0},
      '{dtq_pkg::KIND_REPLY, 48'd106, 4'd0, 32'd0, RV_STOP, 0, dtq_pkg::STAT_OK,  4'd0},
      '{dtq_pkg::KIND_REPLY, 48'd106, 4'd3, 32'd0, RV_KEEP, 0, dtq_pkg::STAT_OK,  4'd0},
      '{dtq_pkg::KIND_REPLY, 48'd106, 4'd2, 32'd0, 32'h7FFF_FFFF, 0, dtq_pkg::STAT_OK, 4'd0},
      '{dtq_pkg::KIND_REPLY,  48'd107, 4'd0, 32'd0, 32'd0,  1, dtq_pkg::STAT_BAD, 4'd0},
      '{dtq_pkg::KIND_CANCEL, 48'd107, 4'd1, 32'd0, 32'd0,  1, dtq_pkg::STAT_OK,  4'd0},
      // far deadline, queued behind the others
      '{dtq_pkg::KIND_ADD, 48'h100_0000_0000, 4'd0, 32'd5, 32'd0, 1, dtq_pkg::STAT_OK, 4'd0},
      '{dtq_pkg::KIND_TICK,  48'd0,   4'd0, 32'd0, 32'd0,   0, dtq_pkg::STAT_OK,  4'd0}
    };

    for (int j = 0; j < NSLOT; j++) begin
      used_m[j] = 0; await_m[j] = 0; dl_m[j] = '0; per_m[j] = '0; rank_m[j] = 0;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed[r])
      send_command(directed[r].kind, directed[r].now, directed[r].id, directed[r].dly,
                   directed[r].rv, directed[r].typed, directed[r].st, directed[r].rid);

    // fill the table, then one add too many
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
    for (int j = 0; j < NSLOT; j++) begin
      slot = -1;
      for (int s = NSLOT - 1; s >= 0; s--) if (!used_m[s]) slot = s;
      if (slot < 0) break;
      send_command(dtq_pkg::KIND_ADD, 48'd200, 4'd0, 32'($urandom_range(0, 3)), 32'd0,
                   1, dtq_pkg::STAT_OK, 4'(slot));
    end
    send_command(dtq_pkg::KIND_ADD, 48'd200, 4'd0, 32'd1, 32'd0, 1, dtq_pkg::STAT_FULL,
                 4'd0);
    // everything due at once
    send_command(dtq_pkg::KIND_TICK, dtq_pkg::MAX48, 4'd0, 32'd0, 32'd0, 0,
                 dtq_pkg::STAT_OK, 4'd0);
    for (int j = 0; j < NSLOT; j++)
      send_command(dtq_pkg::KIND_REPLY, 48'd300, 4'(j), 32'd0, RV_STOP, 0,
                   dtq_pkg::STAT_OK, 4'd0);

    // random traffic on a rising millisecond clock
    clock_ms = 48'd1000;
    for (int n = 0; n < 460; n++) begin
      allow_idle = !(n >= 150 && n < 260);
      if (n == 300) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while (pending_beats.size() != 0);
      end
      clock_ms += 48'($urandom_range(0, 12));
      now = clock_ms;
      if ($urandom_range(99) < 3) now = 48'({$urandom(), $urandom()});
      dly = ($urandom_range(99) < 8) ? $urandom() : 32'($urandom_range(0, 40));
      rv = '0;
      slot = $urandom_range(NSLOT - 1);
      pick = $urandom_range(99);
      if (pick < 30) begin
        kind = dtq_pkg::KIND_ADD;
      end else if (pick < 55) begin
        kind = dtq_pkg::KIND_TICK;
      end else if (pick < 75) begin
        kind = dtq_pkg::KIND_REPLY;
        if ($urandom_range(9) != 0) slot = pick_slot(1'b1);
        case ($urandom_range(3))
          0: rv = {1'b1, 31'($urandom())};
          1: rv = RV_KEEP;
          2: rv = 32'($urandom_range(1, 30));
          default: rv = {1'b0, 31'($urandom())};
        endcase
      end else if (pick < 86) begin
        kind = dtq_pkg::KIND_RESCHED;
        if ($urandom_range(9) != 0) slot = pick_slot(1'b0);
      end else if (pick < 96) begin
        kind = dtq_pkg::KIND_CANCEL;
        if ($urandom_range(9) != 0) slot = pick_slot(1'($urandom_range(1)));
      end else begin
        kind = 3'($urandom_range(5, 7));
      end
      send_command(kind, now, 4'(slot), dly, rv, 0, dtq_pkg::STAT_OK, 4'd0);
    end

    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
    repeat (120) @(posedge clk_i);

    $display("run covered %0d commands and %0d result beats, %0d of them expiries",
             items_sent, beats_seen, expiries_seen);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("tb_deadline_timer_queue: clean");
    end else begin
      $display("tb_deadline_timer_queue: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/dtq_pkg.sv
rtl/dtq_datapath.sv
rtl/dtq_ctrl.sv
rtl/deadline_timer_queue.sv
rtl/dtq_checker.sv
dv/tb_deadline_timer_queue.sv
